### rtl/spq_pkg.sv
// ----------------------------------------------------------------------------
// spq_pkg: shared types for the sorted priority queue
// Command and result words, the stored entry and the per-cycle control word
// that the top level broadcasts to every cell.
// ----------------------------------------------------------------------------
package spq_pkg;

  localparam int unsigned DataW   = 32;
  localparam int unsigned CountOW = 8;

  typedef enum logic [0:0] {
    CMD_INSERT = 1'b0,
    CMD_SERVE  = 1'b1
  } cmd_e;

  typedef enum logic [1:0] {
    ST_INSERTED = 2'd0,
    ST_SERVED   = 2'd1,
    ST_FULL     = 2'd2,
    ST_EMPTY    = 2'd3
  } status_e;

  typedef struct packed {
    cmd_e                    cmd;
    logic signed [DataW-1:0] item_value;
    logic signed [DataW-1:0] item_rank;
  } cmd_word_t;

  typedef struct packed {
    status_e                 status;
    logic signed [DataW-1:0] served_value;
    logic signed [DataW-1:0] served_rank;
    logic [CountOW-1:0]      entry_count;
  } res_word_t;

  // One stored entry.
  typedef struct packed {
    logic signed [DataW-1:0] value;
    logic signed [DataW-1:0] rank;
  } entry_t;

  // Broadcast control: insert and serve are already qualified by full and empty.
  typedef struct packed {
    logic                    insert;
    logic                    serve;
    logic signed [DataW-1:0] new_value;
    logic signed [DataW-1:0] new_rank;
  } cell_ctrl_t;

endpackage

### rtl/spq_if.sv
// ----------------------------------------------------------------------------
// spq_if: valid/ready channels of the sorted priority queue
// One interface for command words and one for result words.
// ----------------------------------------------------------------------------
interface spq_cmd_if;
  logic              valid;
  logic              ready;
  spq_pkg::cmd_word_t word;

  modport source (output valid, output word, input ready);
  modport sink   (input valid, input word, output ready);
endinterface

interface spq_res_if;
  logic              valid;
  logic              ready;
  spq_pkg::res_word_t word;

  modport source (output valid, output word, input ready);
  modport sink   (input valid, input word, output ready);
endinterface

### rtl/spq_cell.sv
// ----------------------------------------------------------------------------
// spq_cell: one slot of the sorted entry chain
// Holds one entry and on each operation keeps it, takes the new entry, or
// takes the entry of its left or right neighbor.
// ----------------------------------------------------------------------------
module spq_cell (
  input  logic                clk_i,
  input  spq_pkg::cell_ctrl_t ctrl_i,
  input  logic                occupied_i,
  input  logic                left_gt_i,
  input  spq_pkg::entry_t     left_i,
  input  spq_pkg::entry_t     right_i,
  output logic                gt_o,
  output spq_pkg::entry_t     entry_o
);
  import spq_pkg::*;

  entry_t entry_q, entry_d;
  logic   gt;

  // An empty slot counts as holding a rank above everything.
  assign gt = !occupied_i || (entry_q.rank > ctrl_i.new_rank);

  always_comb begin
    entry_d = entry_q;
    if (ctrl_i.serve) begin
      entry_d = right_i;
    end else if (ctrl_i.insert && gt) begin
      if (left_gt_i) begin
        entry_d = left_i;
      end else begin
        entry_d.value = ctrl_i.new_value;
        entry_d.rank  = ctrl_i.new_rank;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    entry_q <= entry_d;
  end

  assign gt_o    = gt;
  assign entry_o = entry_q;

endmodule

### rtl/sorted_priority_queue.sv
// ----------------------------------------------------------------------------
// sorted_priority_queue: systolic sorted-array priority queue
// Keeps up to DEPTH entries sorted by ascending signed rank in a row of cells.
// ----------------------------------------------------------------------------
// The queue takes one command word per clock cycle, insert or serve, and
// returns one result word for each in the cycle after it is accepted.
// Entries live in a row of DEPTH cells sorted by rank, smallest at cell 0;
// equal ranks leave in arrival order. An insert is broadcast to every cell,
// each cell compares its rank with the new one, and in the same cycle the
// cells at and after the insert point shift one place right while the new
// entry drops into the gap. A serve reads cell 0 and shifts every cell one
// place left. The command rate is set by the single compare-and-shift step
// in each cell plus the result register; a result waiting for the sink holds
// the command side only while it is not taken. An insert into a full queue
// gives status full and a serve on an empty one gives status empty; neither
// changes the queue. Served fields are zero except on a successful serve, and
// entry_count reports the count after the command, modulo 256. No clearing
// pass is needed after reset: only the count and result valid are reset.
// ----------------------------------------------------------------------------
module sorted_priority_queue #(
  parameter int unsigned DEPTH = 128
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  spq_cmd_if.sink   cmd_i,
  spq_res_if.source res_o
);
  import spq_pkg::*;

  localparam int unsigned CountW = $clog2(DEPTH + 1);

  logic [CountW-1:0] count_q, count_d;
  logic              res_valid_q;
  res_word_t         res_word_q, res_word_d;

  logic       accept;
  logic       full, empty;
  cell_ctrl_t ctrl;

  logic   gt      [DEPTH];
  logic   occupied[DEPTH];
  entry_t entries [DEPTH];

  // The command side stalls only while an untaken result sits in the register.
  assign cmd_i.ready = !res_valid_q || res_o.ready;
  assign accept      = cmd_i.valid && cmd_i.ready;

  assign full  = (count_q == CountW'(DEPTH));
  assign empty = (count_q == '0);

  assign ctrl.insert    = accept && (cmd_i.word.cmd == CMD_INSERT) && !full;
  assign ctrl.serve     = accept && (cmd_i.word.cmd == CMD_SERVE) && !empty;
  assign ctrl.new_value = cmd_i.word.item_value;
  assign ctrl.new_rank  = cmd_i.word.item_rank;

  // The row of cells. Cell 0 is the front of the queue.
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    entry_t left_e, right_e;
    logic   left_gt;

    assign occupied[i] = (count_q > CountW'(i));

    if (i == 0) begin : g_first
      assign left_e  = '0;
      assign left_gt = 1'b0;
    end else begin : g_mid
      assign left_e  = entries[i-1];
      assign left_gt = gt[i-1];
    end

    if (i == DEPTH - 1) begin : g_last
      assign right_e = '0;
    end else begin : g_inner
      assign right_e = entries[i+1];
    end

    spq_cell u_cell (
      .clk_i      (clk_i),
      .ctrl_i     (ctrl),
      .occupied_i (occupied[i]),
      .left_gt_i  (left_gt),
      .left_i     (left_e),
      .right_i    (right_e),
      .gt_o       (gt[i]),
      .entry_o    (entries[i])
    );
  end

  always_comb begin
    count_d = count_q;
    if (ctrl.insert) begin
      count_d = count_q + 1'b1;
    end else if (ctrl.serve) begin
      count_d = count_q - 1'b1;
    end
  end

  // Result word of the command accepted in this cycle.
  always_comb begin
    res_word_d              = '0;
    res_word_d.entry_count  = CountOW'(count_d);
    if (cmd_i.word.cmd == CMD_INSERT) begin
      res_word_d.status = full ? ST_FULL : ST_INSERTED;
    end else if (empty) begin
      res_word_d.status = ST_EMPTY;
    end else begin
      res_word_d.status       = ST_SERVED;
      res_word_d.served_value = entries[0].value;
      res_word_d.served_rank  = entries[0].rank;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      res_valid_q <= 1'b0;
    end else begin
      count_q <= count_d;
      if (accept) begin
        res_valid_q <= 1'b1;
      end else if (res_o.ready) begin
        res_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      res_word_q <= res_word_d;
    end
  end

  assign res_o.valid = res_valid_q;
  assign res_o.word  = res_word_q;

`ifndef ASSERT_OFF
  a_count_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CountW'(DEPTH))
    else $error("entry count above depth");

  a_insert_count : assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctrl.insert |=> count_q == CountW'($past(count_q) + 1'b1))
    else $error("insert did not raise the entry count");

  a_result_follows : assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> res_o.valid)
    else $error("accepted command gave no result");

  a_front_sorted : assert property (@(posedge clk_i) disable iff (!rst_ni)
    occupied[1] |-> !(entries[0].rank > entries[1].rank))
    else $error("front entries out of rank order");

  a_occupied_prefix : assert property (@(posedge clk_i) disable iff (!rst_ni)
    occupied[1] |-> occupied[0])
    else $error("occupied cells not contiguous from the front");
`endif

endmodule

### dv/spq_checker.sv
// ----------------------------------------------------------------------------
// spq_checker: scoreboard for the sorted priority queue
// Watches the command and result channels, keeps a shadow copy of the sorted
// entry row, predicts one result word per accepted command and compares each
// accepted result word with the oldest prediction.
// ----------------------------------------------------------------------------
module spq_checker #(
  parameter int unsigned DEPTH = 128
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  spq_cmd_if          cmd_mon,
  spq_res_if          res_mon,
  output int unsigned fail_count_o,
  output int unsigned pending_o
);
  import spq_pkg::*;

  // Shadow of the entry row, smallest rank at index 0.
  entry_t      shadow_row [DEPTH];
  int unsigned occupancy;
  int unsigned fails;
  res_word_t   awaited_results [$];

  // Applies one command to the shadow row and returns the result word it gives.
  function automatic res_word_t apply_command(cmd_word_t w);
    res_word_t   r;
    int unsigned pos;
    r = '0;
    if (w.cmd == CMD_INSERT) begin
      if (occupancy >= DEPTH) begin
        r.status = ST_FULL;
      end else begin
        // New entry goes behind every entry whose rank is not greater.
        pos = occupancy;
        while (pos > 0 && shadow_row[pos-1].rank > w.item_rank) begin
          shadow_row[pos] = shadow_row[pos-1];
          pos--;
        end
        shadow_row[pos].value = w.item_value;
        shadow_row[pos].rank  = w.item_rank;
        occupancy++;
        r.status = ST_INSERTED;
      end
    end else begin
      if (occupancy == 0) begin
        r.status = ST_EMPTY;
      end else begin
        r.served_value = shadow_row[0].value;
        r.served_rank  = shadow_row[0].rank;
        for (int unsigned k = 0; k + 1 < occupancy; k++) begin
          shadow_row[k] = shadow_row[k+1];
        end
        occupancy--;
        r.status = ST_SERVED;
      end
    end
    r.entry_count = CountOW'(occupancy);
    return r;
  endfunction

  task automatic check_field(string name, logic signed [63:0] want, logic signed [63:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
      fails++;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin : watch
    res_word_t want;
    res_word_t got;
    if (!rst_ni) begin
      occupancy = 0;
      fails     = 0;
      awaited_results.delete();
    end else begin
      if (cmd_mon.valid && cmd_mon.ready) begin
        awaited_results.push_back(apply_command(cmd_mon.word));
      end
      if (res_mon.valid && res_mon.ready) begin
        got = res_mon.word;
        if (awaited_results.size() == 0) begin
          $display("%0t: unexpected result word, expected none, got status %0d",
                   $time, got.status);
          fails++;
        end else begin
          want = awaited_results.pop_front();
          check_field("status", want.status, got.status);
          check_field("served_value", want.served_value, got.served_value);
          check_field("served_rank", want.served_rank, got.served_rank);
          check_field("entry_count", want.entry_count, got.entry_count);
        end
      end
    end
    fail_count_o <= fails;
    pending_o    <= awaited_results.size();
  end

endmodule

### dv/tb.sv
// ----------------------------------------------------------------------------
// tb: testbench top for the sorted priority queue
// Drives command words and takes result words with random gaps and stalls,
// while the checker beside the queue predicts and compares every result.
// ----------------------------------------------------------------------------
// The run starts with a short directed sequence: a serve on an empty queue,
// inserts with the extreme data and rank values, several equal ranks to show
// arrival order among ties, and serves that drain the queue and go one past
// empty. The random part then cycles through three traffic modes. A fill mode
// that mostly inserts pushes the queue to DEPTH and keeps inserting until
// several inserts have been rejected as full. A drain mode that mostly serves
// empties it again and keeps serving until two serves have been rejected
// as empty. A mixed mode sits in between. Ranks are drawn often from a narrow
// band so that ties are common, sometimes from the extremes of the signed
// range and otherwise from the whole range, so that every bit toggles.
// ----------------------------------------------------------------------------
module tb;
  import spq_pkg::*;

  localparam int unsigned Depth      = 128;
  localparam int unsigned ItemsTotal = 2022;
  localparam int unsigned IdlePct    = 37;

  typedef enum logic [1:0] {
    MODE_FILL,
    MODE_DRAIN,
    MODE_MIX
  } traffic_mode_e;

  logic        clk_i  = 1'b0;
  logic        rst_ni = 1'b0;
  int unsigned fail_count;
  int unsigned pending;

  // Stimulus bookkeeping: the top keeps no entries, only counters (fill level among them) to steer traffic.
  int unsigned   fill_level = 0;
  int unsigned   words_sent = 0;
  int unsigned   full_hits  = 0;
  int unsigned   empty_hits = 0;
  int unsigned   cycle_no   = 0;

  spq_cmd_if cmd_if ();
  spq_res_if res_if ();

  sorted_priority_queue #(
    .DEPTH(Depth)
  ) uut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .cmd_i (cmd_if.sink),
    .res_o (res_if.source)
  );

  spq_checker #(
    .DEPTH(Depth)
  ) u_checker (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_mon     (cmd_if),
    .res_mon     (res_if),
    .fail_count_o(fail_count),
    .pending_o   (pending)
  );

  always #1 clk_i = ~clk_i;

  // The result side stalls at random, except for a stretch in the middle of
  // the run where it always takes the word.
  always @(posedge clk_i) begin
    cycle_no <= cycle_no + 1;
    if (cycle_no >= 1500 && cycle_no < 2700) begin
      res_if.ready <= 1'b1;
    end else begin
      res_if.ready <= ($urandom_range(99) >= IdlePct);
    end
  end

  // Ranks: a narrow band around zero for ties, the signed extremes and their
  // neighbors, or any 32-bit pattern.
  function automatic logic signed [DataW-1:0] pick_rank();
    logic signed [DataW-1:0] r;
    case ($urandom_range(9))
      0, 1, 2, 3: r = $urandom_range(8) - 4;
      4, 5: begin
        case ($urandom_range(5))
          0:       r = 32'sh8000_0000;
          1:       r = 32'sh8000_0001;
          2:       r = 32'sh7fff_ffff;
          3:       r = 32'sh7fff_fffe;
          4:       r = '0;
          default: r = '1;
        endcase
      end
      default: r = $urandom;
    endcase
    return r;
  endfunction

  // Sends one command word. Random idle cycles come first, unless the word
  // falls into the stretch where the command side never idles. The valid
  // stays high from one word to the next when no gap is drawn.
  task automatic send_word(cmd_e c, logic signed [DataW-1:0] v, logic signed [DataW-1:0] r);
    bit steady;
    steady = (words_sent >= 700 && words_sent < 1100);
    while (!steady && $urandom_range(99) < IdlePct) begin
      cmd_if.valid <= 1'b0;
      @(posedge clk_i);
    end
    cmd_if.valid <= 1'b1;
    cmd_if.word  <= '{cmd: c, item_value: v, item_rank: r};
    do @(posedge clk_i); while (!cmd_if.ready);
    words_sent++;
    if (c == CMD_INSERT) begin
      if (fill_level == Depth) full_hits++;
      else fill_level++;
    end else begin
      if (fill_level == 0) empty_hits++;
      else fill_level--;
    end
  endtask

  initial begin : stimulus
    traffic_mode_e mode;
    int unsigned   mix_left;
    int unsigned   insert_pct;
    cmd_e          c;

    cmd_if.valid = 1'b0;
    cmd_if.word  = '0;
    res_if.ready = 1'b0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed part. A serve on the empty queue comes first.
    send_word(CMD_SERVE, $urandom, $urandom);
    // Extreme data and ranks, then zero and minus one.
    send_word(CMD_INSERT, 32'sh7fff_ffff, 32'sh7fff_ffff);
    send_word(CMD_INSERT, 32'sh8000_0000, 32'sh8000_0000);
    send_word(CMD_INSERT, 32'sh0000_0000, 32'sh0000_0000);
    send_word(CMD_INSERT, 32'shffff_ffff, 32'shffff_ffff);
    // Three equal ranks must leave in arrival order.
    send_word(CMD_INSERT, 32'sd11, 32'sd5);
    send_word(CMD_INSERT, 32'sd12, 32'sd5);
    send_word(CMD_INSERT, 32'sd13, 32'sd5);
    // Ties with the smallest and the largest rank already stored, then a new rank.
    send_word(CMD_INSERT, 32'sd14, 32'sh8000_0000);
    send_word(CMD_INSERT, 32'sd15, 32'sh7fff_ffff);
    send_word(CMD_INSERT, 32'sd16, 32'sd1);
    // Drain all ten entries and serve once more on the empty queue.
    repeat (11) send_word(CMD_SERVE, $urandom, $urandom);

    // Random part, steered by the traffic mode.
    mode      = MODE_FILL;
    mix_left  = 0;
    full_hits = 0;
    while (words_sent < ItemsTotal) begin
      case (mode)
        MODE_FILL: begin
          if (fill_level == Depth && full_hits >= 3) begin
            mode       = MODE_DRAIN;
            empty_hits = 0;
          end
        end
        MODE_DRAIN: begin
          if (fill_level == 0 && empty_hits >= 2) begin
            mode     = MODE_MIX;
            mix_left = 150;
          end
        end
        default: begin
          if (mix_left == 0) begin
            mode      = MODE_FILL;
            full_hits = 0;
          end
        end
      endcase
      case (mode)
        MODE_FILL:  insert_pct = 85;
        MODE_DRAIN: insert_pct = 15;
        default: begin
          insert_pct = 50;
          mix_left--;
        end
      endcase
      c = ($urandom_range(99) < insert_pct) ? CMD_INSERT : CMD_SERVE;
      send_word(c, $urandom, pick_rank());
    end

    // Let the last results come out, then keep watching for anything stray.
    cmd_if.valid <= 1'b0;
    do @(posedge clk_i); while (pending != 0);
    repeat (10) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

  // Watchdog: the whole run needs well under a tenth of this.
  initial begin : watchdog
    #400000;
    $display("status: fail");
    $finish;
  end

endmodule

### files.f
rtl/spq_pkg.sv
rtl/spq_if.sv
rtl/spq_cell.sv
rtl/sorted_priority_queue.sv
dv/spq_checker.sv
dv/tb.sv
